// File: hdl/fnsw_pkg.sv
package fnsw_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 9;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] first_negative;
		logic                       found;
	} out_item_t;

endpackage

// File: hdl/first_negative_in_sliding_window_unit.sv
// First negative sample in a sliding window.
// Input channel (in_valid / in_stall / in_item): one item per sample, carrying the
// signed sample and a restart flag that empties the queue and the fill count first.
// Output channel (out_valid / out_stall / out_item): once window_size items have
// arrived since the last restart, every item yields one result, the oldest negative
// still inside the window (found = 1) or zero (found = 0).
// Configuration channel (cfg_valid / cfg_ready / cfg_data): window_size, 1..MAX_WINDOW;
// zero acts as 1, larger values as MAX_WINDOW. cfg_ready is always high. Write it
// only while no item is in flight.
// Each result is registered, in the output register or, on a stall, the skid register.
// Throughput: one item per cycle while in_stall is low. The negatives queue lives in
// one synchronous memory that is read ahead; the head and second entries sit in
// registers so that a pop and a push each cycle need only that one read port.
// Receiver stall: a skid register catches one result; while it is full in_stall is
// high, and it drains into the output register on the next accepted result.
// Reset: queue empty, fill count and stream position zero, window_size 1. The memory
// is not cleared; only occupied entries are ever used.
module first_negative_in_sliding_window_unit #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [8:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fnsw_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fnsw_pkg::out_item_t  out_item
);
	import fnsw_pkg::*;

	// Index, position (modulo twice the window) and count widths.
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int PW = $clog2(2 * MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int XW0 = (PW > CW) ? PW : CW;
	localparam int XW = (XW0 > WIN_W) ? XW0 : WIN_W;

	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_WINDOW - 1);
	localparam logic [PW-1:0] POS_LAST = PW'(2 * MAX_WINDOW - 1);
	localparam logic [PW:0]   POS_MOD  = (PW + 1)'(2 * MAX_WINDOW);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_WINDOW);
	localparam logic [XW-1:0] K_MAX    = XW'(MAX_WINDOW);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
		idx_inc = (x == IDX_LAST) ? '0 : x + 1'b1;
	endfunction

	// Queue storage: values and positions, one read port with registered data.
	logic [SAMPLE_W-1:0] val_mem [MAX_WINDOW];
	logic [PW-1:0]       pos_mem [MAX_WINDOW];

	// Control state.
	logic [WIN_W-1:0] win_size_q;
	logic [IW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q, fill_q;
	logic [PW-1:0]    pos_q;
	logic             fwd_hit_s1;
	logic             skid_valid_q;

	// Front of the queue held in registers: head entry and the one behind it.
	logic [SAMPLE_W-1:0] f0_val_q, f1_val_q;
	logic [PW-1:0]       f0_pos_q, f1_pos_q;

	// Third entry, read ahead from memory, with a bypass for a same-cycle write.
	logic [SAMPLE_W-1:0] rd_val_s1, fwd_val_s1;
	logic [PW-1:0]       rd_pos_s1, fwd_pos_s1;

	out_item_t main_q, skid_q;

	logic                accept, take, push, pop, emit;
	logic [XW-1:0]       k_eff, head_age_x;
	logic [PW:0]         head_age;
	logic [IW-1:0]       h0, t0, h1, t1, rd_addr;
	logic [CW-1:0]       c0, c1, c2, fill0, fill1;
	logic [PW-1:0]       pos_next;
	logic [SAMPLE_W-1:0] third_val, s0_val, s1_val;
	logic [PW-1:0]       third_pos, s0_pos, s1_pos;
	out_item_t           result;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !in_stall;
	assign take      = out_valid && !out_stall;
	assign out_item  = main_q;

	always_comb begin
		// Clamp the window size.
		if (win_size_q == '0) begin
			k_eff = XW'(1);
		end else if (XW'(win_size_q) > K_MAX) begin
			k_eff = K_MAX;
		end else begin
			k_eff = XW'(win_size_q);
		end

		// Restart empties the queue before the item is taken.
		c0    = in_item.restart ? '0 : count_q;
		h0    = in_item.restart ? '0 : head_q;
		t0    = in_item.restart ? '0 : tail_q;
		fill0 = in_item.restart ? '0 : fill_q;

		// Age of the head entry, modulo the position range.
		head_age = {1'b0, pos_q} + ((pos_q < f0_pos_q) ? POS_MOD : '0) - {1'b0, f0_pos_q};
		head_age_x = XW'(head_age);

		// Drop the head once it has left the window, then push a negative.
		pop  = (c0 != '0) && (head_age_x >= k_eff);
		c1   = c0 - CW'(pop);
		h1   = pop ? idx_inc(h0) : h0;
		push = in_item.sample[SAMPLE_W-1] && (c1 < CNT_MAX);
		c2   = c1 + CW'(push);
		t1   = push ? idx_inc(t0) : t0;

		third_val = fwd_hit_s1 ? fwd_val_s1 : rd_val_s1;
		third_pos = fwd_hit_s1 ? fwd_pos_s1 : rd_pos_s1;

		// New head slot.
		if (c1 != '0) begin
			s0_val = pop ? f1_val_q : f0_val_q;
			s0_pos = pop ? f1_pos_q : f0_pos_q;
		end else begin
			s0_val = in_item.sample;
			s0_pos = pos_q;
		end

		// New second slot.
		if (c1 > CW'(1)) begin
			s1_val = pop ? third_val : f1_val_q;
			s1_pos = pop ? third_pos : f1_pos_q;
		end else if (c1 == CW'(1)) begin
			s1_val = in_item.sample;
			s1_pos = pos_q;
		end else begin
			s1_val = f1_val_q;
			s1_pos = f1_pos_q;
		end

		pos_next = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		fill1    = (XW'(fill0) < k_eff) ? fill0 + 1'b1 : fill0;
		emit     = accept && (XW'(fill1) >= k_eff);

		result.found          = (c2 != '0);
		result.first_negative = (c2 != '0) ? s0_val : '0;

		// Read ahead the entry two behind the next head.
		rd_addr = accept ? idx_inc(idx_inc(h1)) : idx_inc(idx_inc(head_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q   <= WIN_W'(1);
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			fill_q       <= '0;
			pos_q        <= '0;
			fwd_hit_s1   <= 1'b0;
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_size_q <= cfg_data;
			end
			if (accept) begin
				head_q  <= h1;
				tail_q  <= t1;
				count_q <= c2;
				fill_q  <= fill1;
				pos_q   <= pos_next;
			end
			fwd_hit_s1 <= accept && push && (t0 == rd_addr);
			// Output register and skid.
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid <= emit;
				end
			end else if (!out_valid) begin
				out_valid <= emit;
			end else if (emit) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f0_val_q <= s0_val;
			f0_pos_q <= s0_pos;
			f1_val_q <= s1_val;
			f1_pos_q <= s1_pos;
		end
		fwd_val_s1 <= in_item.sample;
		fwd_pos_s1 <= pos_q;
		if (take) begin
			main_q <= skid_valid_q ? skid_q : result;
		end else if (!out_valid) begin
			main_q <= result;
		end else if (emit) begin
			skid_q <= result;
		end
	end

	// Queue memory: write at the tail, read ahead.
	always_ff @(posedge clk) begin
		if (accept && push) begin
			val_mem[t0] <= in_item.sample;
			pos_mem[t0] <= pos_q;
		end
		rd_val_s1 <= val_mem[rd_addr];
		rd_pos_s1 <= pos_mem[rd_addr];
	end

	// A full skid implies a waiting result in the output register.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid)
		else $error("skid holds a result while the output register is empty");

	// Occupancy never exceeds the memory depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("queue count beyond depth");

	// On an empty queue the tail equals the head.
	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (tail_q == head_q))
		else $error("tail and head disagree on an empty queue");

	// A found result is negative; otherwise the value is zero.
	a_result_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.found ? out_item.first_negative[SAMPLE_W-1]
			: (out_item.first_negative == '0)))
		else $error("result value inconsistent with found flag");

endmodule

// File: verif/first_negative_window_checker.sv
`timescale 1ns / 100ps

module first_negative_window_checker #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fnsw_pkg::WIN_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  fnsw_pkg::in_item_t             in_item,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  fnsw_pkg::out_item_t            out_item,
	output int                             mismatches,
	output int                             pending,
	output int                             results,
	output int                             hits
);
	import fnsw_pkg::*;

	localparam int PW = $clog2(2 * MAX_WINDOW);
	localparam int QW = $clog2(MAX_WINDOW);

	// own copy of the block state
	logic [WIN_W-1:0]          window_reg;
	logic signed [SAMPLE_W-1:0] neg_value [MAX_WINDOW];
	logic [PW-1:0]             neg_stamp [MAX_WINDOW];
	logic [QW-1:0]             oldest;
	logic [QW-1:0]             newest;
	logic [QW:0]               held;
	logic [PW-1:0]             stamp;
	int                        filled;

	out_item_t expected_firsts[$];

	function automatic int span();
		if (window_reg == 0)
			return 1;
		if (window_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(window_reg);
	endfunction

	// advance the window by one sample; returns 1 when a result is due
	function automatic bit slide_window(input in_item_t it, output out_item_t first);
		int            k;
		logic [PW-1:0] age;
		k = span();
		first = '0;
		if (it.restart) begin
			oldest = '0;
			newest = '0;
			held   = '0;
			filled = 0;
		end
		// only the head is checked, so at most one entry ages out per sample
		if (held != 0) begin
			age = stamp - neg_stamp[oldest];
			if (age >= k) begin
				oldest++;
				held--;
			end
		end
		if (it.sample[SAMPLE_W-1] && held < MAX_WINDOW) begin
			neg_value[newest] = it.sample;
			neg_stamp[newest] = stamp;
			newest++;
			held++;
		end
		stamp++;
		if (filled < k)
			filled++;
		if (filled < k)
			return 1'b0;
		first.found          = (held != 0);
		first.first_negative = (held != 0) ? neg_value[oldest] : '0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			window_reg = WIN_W'(1);
			oldest     = '0;
			newest     = '0;
			held       = '0;
			stamp      = '0;
			filled     = 0;
			expected_firsts.delete();
			mismatches = 0;
			pending    = 0;
			results    = 0;
			hits       = 0;
		end else begin
			// results first: one accepted now belongs to an earlier item
			if (out_valid && !out_stall) begin
				results++;
				if (out_item.found)
					hits++;
				if (expected_firsts.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result %0d found %0b arrived with none outstanding",
							$time, out_item.first_negative, out_item.found);
					mismatches++;
				end else begin
					want = expected_firsts.pop_front();
					if (out_item.first_negative !== want.first_negative ||
							out_item.found !== want.found) begin
						if (mismatches < 10)
							$display("%0t: wanted first_negative %0d found %0b, got %0d found %0b",
								$time, want.first_negative, want.found,
								out_item.first_negative, out_item.found);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			if (in_valid && !in_stall) begin
				if (slide_window(in_item, got))
					expected_firsts.insert(expected_firsts.size(), got);
			end
			pending = expected_firsts.size();
		end
	end

endmodule

// File: verif/first_negative_in_sliding_window_unit_test.sv
`timescale 1ns / 100ps

module first_negative_in_sliding_window_unit_test;
	import fnsw_pkg::*;

	localparam int MAX_WINDOW    = 256;
	// long receiver hold-off, long enough to fill the output skid and stall the input
	localparam int HOLD_CYCLES   = 120;
	// results are registered after their item is taken; allow a little margin before idle writes
	localparam int SETTLE_CYCLES = 4;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [WIN_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_item;

	int mismatches;
	int pending;
	int results;
	int hits;

	int hold_req;       // bumped by the sender side to ask for one long hold-off
	int items_taken;
	int settings_used;
	int burst_left;
	bit steady;         // no gaps between items while set

	first_negative_in_sliding_window_unit #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	first_negative_window_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.mismatches(mismatches),
		.pending   (pending),
		.results   (results),
		.hits      (hits)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case the handshakes lock up
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Receiver: stall on a pattern of its own, switching between modes every so
	// often, and honour a request for one long hold-off counted here in cycles.
	initial begin : receiver
		int mode;
		int left;
		int holds_done;
		int tick;
		mode       = 0;
		left       = 0;
		holds_done = 0;
		tick       = 0;
		out_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((tick % 7) < 3);
				endcase
			end
		end
	end

	// Offer one item and hold it until taken. Bursts of random length are
	// separated by random gaps, except while steady is set.
	task automatic offer(input logic signed [SAMPLE_W-1:0] value, input logic restart);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= '{sample: value, restart: restart};
		do @(posedge clk); while (in_stall);
		items_taken++;
	endtask

	// Drop valid and wait until every outstanding result has been seen.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Write the window size once the block has gone quiet. Items still filling
	// the window give no result, so let a few more cycles pass before the write.
	task automatic write_window(input logic [WIN_W-1:0] value);
		settle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Draw a sample: negative with the given percentage, extremes now and then.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int neg_pct);
		logic [SAMPLE_W-2:0] bits;
		int                  roll;
		bits = (SAMPLE_W-1)'($urandom());
		roll = $urandom_range(0, 19);
		if ($urandom_range(0, 99) < neg_pct) begin
			case (roll)
				0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
				1: return '1;
				default: return {1'b1, bits};
			endcase
		end
		case (roll)
			0: return '0;
			1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
			default: return {1'b0, bits};
		endcase
	endfunction

	// One random phase at a fixed setting. Restarts are rare against the window
	// so that most stretches fill it and go on to yield results. Optionally ask
	// for the long hold-off (sending without gaps) or pause until drained.
	task automatic run_phase(input logic [WIN_W-1:0] setting, input int count,
			input int neg_pct, input bit fresh, input int hold_at, input int pause_at);
		int   width;
		logic restart;
		write_window(setting);
		width  = (setting == 0) ? 1 : ((setting > MAX_WINDOW) ? MAX_WINDOW : int'(setting));
		steady = (hold_at >= 0);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req <= hold_req + 1;
			if (i == pause_at)
				settle();
			restart = (i == 0) ? fresh : ($urandom_range(0, 3 * width + 20) == 0);
			offer(pick_sample(neg_pct), restart);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		in_item       = '0;
		hold_req      = 0;
		items_taken   = 0;
		settings_used = 0;
		burst_left    = 0;
		steady        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// window of one straight after reset: every item answers for itself
		offer(16'sh8000, 1'b0);
		offer(16'sh7fff, 1'b0);
		offer(16'sh0000, 1'b0);
		offer(16'shffff, 1'b0);
		offer(16'sh0001, 1'b0);
		offer(-16'sd5,   1'b1);

		// window of three: fill, a negative ageing out, an empty window,
		// then a restart part way through so the window fills afresh
		write_window(9'd3);
		offer(-16'sd2, 1'b1);
		offer(16'sd5,  1'b0);
		offer(16'sd7,  1'b0);
		offer(16'sd8,  1'b0);
		offer(16'sd9,  1'b0);
		offer(-16'sd3, 1'b0);
		offer(16'sd4,  1'b1);
		offer(-16'sd4, 1'b0);
		offer(16'sd6,  1'b0);
		offer(16'sd1,  1'b0);
		offer(16'sd2,  1'b0);

		// shrink the window without a restart: stale entries leave one per sample
		write_window(9'd4);
		offer(-16'sd7,  1'b1);
		offer(-16'sd8,  1'b0);
		offer(-16'sd9,  1'b0);
		offer(-16'sd10, 1'b0);
		write_window(9'd1);
		offer(16'sd3,   1'b0);
		offer(-16'sd11, 1'b0);
		offer(16'sd5,   1'b0);

		// random phases: largest window, then shrink with the long hold-off,
		// zero and oversize settings, and pauses until drained
		run_phase(9'd256, 330, 30, 1'b1, -1, -1);
		run_phase(9'd2,    90, 70, 1'b0, 10, -1);
		run_phase(9'd0,    60, 50, 1'($urandom_range(0, 1)), -1, -1);
		run_phase(9'd511, 300, 60, 1'b0, -1, 150);
		run_phase(9'd17,  100, 20, 1'($urandom_range(0, 1)), -1, 50);
		run_phase(9'd5,    60, 90, 1'b0, -1, -1);
		run_phase(9'd1,    40, 50, 1'b1, -1, -1);

		// drain, then give any stray result time to show up
		settle();
		repeat (10) @(negedge clk);

		$display("Run took %0d items across %0d window writes after the reset setting",
			items_taken, settings_used);
		$display("Saw %0d results, %0d of them holding a negative sample", results, hits);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
